FILE: src/rsps_pkg.sv
// Shared types, command codes and the status pattern table of the RGB status sequencer.
// Used by rsps_engine, rsps_out_reg and rgb_status_pattern_sequencer. No dependencies.
package rsps_pkg;

    localparam int CNT_W = 4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [2:0] ST_INIT            = 3'd0;
    localparam logic [2:0] ST_VOLUME          = 3'd1;
    localparam logic [2:0] ST_LED_CHANGED     = 3'd2;
    localparam logic [2:0] ST_CHANNEL_CHANGED = 3'd3;
    localparam logic [2:0] ST_IDLE            = 3'd4;

    localparam logic [63:0] BRIGHT_FULL  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BRIGHT_BLINK = 64'h00FF_00FF_00FF_00FF;
    localparam logic [63:0] BRIGHT_OFF   = 64'h0000_0000_0000_0000;
    localparam logic [7:0]  COLOR_ON     = 8'hFF;
    localparam logic [7:0]  COLOR_OFF    = 8'h00;
    localparam logic [3:0]  LOW_NIBBLE   = 4'hF;

    typedef struct packed {
        logic        known;
        logic [63:0] bright;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } status_entry_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } result_t;

    function automatic status_entry_t status_lookup(input logic [2:0] code);
        status_entry_t e;
        e = '{known: 1'b0, bright: BRIGHT_OFF, red: COLOR_OFF, green: COLOR_OFF,
              blue: COLOR_OFF};
        case (code)
            ST_INIT:
                e = '{known: 1'b1, bright: BRIGHT_FULL, red: COLOR_ON,
                      green: COLOR_OFF, blue: COLOR_OFF};
            ST_VOLUME:
                e = '{known: 1'b1, bright: BRIGHT_FULL, red: COLOR_OFF,
                      green: COLOR_OFF, blue: COLOR_ON};
            ST_LED_CHANGED:
                e = '{known: 1'b1, bright: BRIGHT_BLINK, red: COLOR_OFF,
                      green: COLOR_ON, blue: COLOR_OFF};
            ST_CHANNEL_CHANGED:
                e = '{known: 1'b1, bright: BRIGHT_FULL, red: COLOR_OFF,
                      green: COLOR_ON, blue: COLOR_OFF};
            ST_IDLE:
                e = '{known: 1'b1, bright: BRIGHT_OFF, red: COLOR_ON,
                      green: COLOR_ON, blue: COLOR_OFF};
            default:
                e.known = 1'b0;
        endcase
        return e;
    endfunction

endpackage

FILE: src/rsps_engine.sv
// Pattern state of the RGB status sequencer: patterns, shadow colors, indices and swap countdown.
// Forms the result of a tick from the current state. Depends on rsps_pkg.
module rsps_engine #(
    parameter int SWAP_DELAY_TICKS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             cmd,
    input  logic [2:0]       status_code,
    input  logic             defer_colors,
    output rsps_pkg::result_t result
);

    localparam logic [rsps_pkg::CNT_W-1:0] RELOAD = rsps_pkg::CNT_W'(SWAP_DELAY_TICKS);

    logic [63:0]                 pattern_reg;
    logic [7:0]                  red_act_reg, green_act_reg, blue_act_reg;
    logic [7:0]                  red_sh_reg, green_sh_reg, blue_sh_reg;
    logic                        pending_reg;
    logic [rsps_pkg::CNT_W-1:0]  count_reg;
    logic [2:0]                  bit_idx_reg;
    logic [3:0]                  nib_idx_reg;

    rsps_pkg::status_entry_t     entry;
    logic [rsps_pkg::CNT_W-1:0]  count_dec;
    logic [3:0]                  nibble;

    assign entry     = rsps_pkg::status_lookup(status_code);
    assign count_dec = count_reg - 1'b1;
    assign nibble    = pattern_reg[{~nib_idx_reg, 2'b00} +: 4];

    assign result.brightness = {nibble, rsps_pkg::LOW_NIBBLE};
    assign result.red        = {8{red_act_reg[bit_idx_reg]}};
    assign result.green      = {8{green_act_reg[bit_idx_reg]}};
    assign result.blue       = {8{blue_act_reg[bit_idx_reg]}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            red_act_reg   <= '0;
            green_act_reg <= '0;
            blue_act_reg  <= '0;
            red_sh_reg    <= '0;
            green_sh_reg  <= '0;
            blue_sh_reg   <= '0;
            pending_reg   <= 1'b0;
            count_reg     <= RELOAD;
            bit_idx_reg   <= '0;
            nib_idx_reg   <= '0;
        end
        else if (step)
        begin
            if (cmd == rsps_pkg::CMD_SET)
            begin
                pending_reg <= defer_colors;
                if (entry.known)
                begin
                    pattern_reg <= entry.bright;
                    if (defer_colors)
                    begin
                        red_sh_reg   <= entry.red;
                        green_sh_reg <= entry.green;
                        blue_sh_reg  <= entry.blue;
                    end
                    else
                    begin
                        red_act_reg   <= entry.red;
                        green_act_reg <= entry.green;
                        blue_act_reg  <= entry.blue;
                    end
                end
            end
            else
            begin
                bit_idx_reg <= bit_idx_reg + 1'b1;
                nib_idx_reg <= nib_idx_reg + 1'b1;
                if (pending_reg)
                begin
                    if (count_dec == '0)
                    begin
                        pending_reg   <= 1'b0;
                        count_reg     <= RELOAD;
                        red_act_reg   <= red_sh_reg;
                        green_act_reg <= green_sh_reg;
                        blue_act_reg  <= blue_sh_reg;
                    end
                    else
                    begin
                        count_reg <= count_dec;
                    end
                end
            end
        end
    end

endmodule

FILE: src/rsps_out_reg.sv
// Result register of the RGB status sequencer: holds one finished result until it is taken.
// Depends on rsps_pkg.
module rsps_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rsps_pkg::result_t result,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              free,
    output rsps_pkg::result_t held
);

    logic              valid_reg;
    logic              valid_next;
    rsps_pkg::result_t data_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign held       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

FILE: src/rgb_status_pattern_sequencer.sv
// Top level of the RGB status LED pattern sequencer: input register, pattern engine, result register.
// Depends on rsps_pkg, rsps_engine and rsps_out_reg.
//
//   Channel | Valid     | Stall     | Payload
//   input   | in_valid  | in_stall  | cmd, status_code, defer_colors
//   output  | out_valid | out_stall | brightness, red, green, blue
//
// Each request is held in the input register and is processed at the edge that empties it.
// A tick request's result enters the result register as the request leaves the input register.
// A set request produces no result and updates the patterns as it leaves the input register.
// A request is accepted in every cycle unless a tick waits behind a stalled result.
// Reset clears all patterns and indices and loads the swap countdown with SWAP_DELAY_TICKS.
module rgb_status_pattern_sequencer #(
    parameter int SWAP_DELAY_TICKS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [2:0] status_code,
    input  logic       defer_colors,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] brightness,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              cmd_reg;
    logic [2:0]        code_reg;
    logic              defer_reg;
    logic              out_free;
    logic              advance;
    logic              take;
    rsps_pkg::result_t result;
    rsps_pkg::result_t held;

    assign advance       = in_valid_reg && (cmd_reg == rsps_pkg::CMD_SET || out_free);
    assign in_stall      = in_valid_reg && !advance;
    assign take          = in_valid && !in_stall;
    assign in_valid_next = take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= cmd;
            code_reg  <= status_code;
            defer_reg <= defer_colors;
        end
    end

    rsps_engine #(
        .SWAP_DELAY_TICKS(SWAP_DELAY_TICKS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .cmd          (cmd_reg),
        .status_code  (code_reg),
        .defer_colors (defer_reg),
        .result       (result)
    );

    rsps_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && cmd_reg == rsps_pkg::CMD_TICK),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (out_free),
        .held      (held)
    );

    assign brightness = held.brightness;
    assign red        = held.red;
    assign green      = held.green;
    assign blue       = held.blue;

endmodule

FILE: tb/rgb_status_pattern_sequencer_tb.sv
// Self-checking testbench for the RGB status LED pattern sequencer.
// It holds a scoreboard class that predicts every tick result and compares it as it arrives.
// Depends on rsps_pkg and rgb_status_pattern_sequencer.
`timescale 1ns / 1ps

module rgb_status_pattern_sequencer_tb;

    localparam int SWAP_TICKS   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_COUNT = 900;
    localparam int HOLD_CYCLES  = 400;

    class status_scoreboard;
        logic [63:0]       bright_pat;
        logic [7:0]        red_on;
        logic [7:0]        green_on;
        logic [7:0]        blue_on;
        logic [7:0]        red_next;
        logic [7:0]        green_next;
        logic [7:0]        blue_next;
        bit                swap_pending;
        logic [3:0]        swap_count;
        logic [2:0]        bit_idx;
        logic [3:0]        nib_idx;
        rsps_pkg::result_t expected_q[$];
        int                errors;

        function new();
            bright_pat   = rsps_pkg::BRIGHT_OFF;
            red_on       = rsps_pkg::COLOR_OFF;
            green_on     = rsps_pkg::COLOR_OFF;
            blue_on      = rsps_pkg::COLOR_OFF;
            red_next     = rsps_pkg::COLOR_OFF;
            green_next   = rsps_pkg::COLOR_OFF;
            blue_next    = rsps_pkg::COLOR_OFF;
            swap_pending = 1'b0;
            swap_count   = 4'(SWAP_TICKS);
            bit_idx      = '0;
            nib_idx      = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic c, logic [2:0] code, logic defer);
            logic [63:0]       b;
            logic [7:0]        r;
            logic [7:0]        g;
            logic [7:0]        bl;
            bit                known;
            rsps_pkg::result_t res;
            int                sh;
            known = 1'b1;
            b     = rsps_pkg::BRIGHT_OFF;
            r     = rsps_pkg::COLOR_OFF;
            g     = rsps_pkg::COLOR_OFF;
            bl    = rsps_pkg::COLOR_OFF;
            if (c == rsps_pkg::CMD_SET)
            begin
                case (code)
                    rsps_pkg::ST_INIT:
                    begin
                        b = rsps_pkg::BRIGHT_FULL;
                        r = rsps_pkg::COLOR_ON;
                    end
                    rsps_pkg::ST_VOLUME:
                    begin
                        b  = rsps_pkg::BRIGHT_FULL;
                        bl = rsps_pkg::COLOR_ON;
                    end
                    rsps_pkg::ST_LED_CHANGED:
                    begin
                        b = rsps_pkg::BRIGHT_BLINK;
                        g = rsps_pkg::COLOR_ON;
                    end
                    rsps_pkg::ST_CHANNEL_CHANGED:
                    begin
                        b = rsps_pkg::BRIGHT_FULL;
                        g = rsps_pkg::COLOR_ON;
                    end
                    rsps_pkg::ST_IDLE:
                    begin
                        b = rsps_pkg::BRIGHT_OFF;
                        r = rsps_pkg::COLOR_ON;
                        g = rsps_pkg::COLOR_ON;
                    end
                    default:
                        known = 1'b0;
                endcase
                swap_pending = defer;
                if (known)
                begin
                    bright_pat = b;
                    if (defer)
                    begin
                        red_next   = r;
                        green_next = g;
                        blue_next  = bl;
                    end
                    else
                    begin
                        red_on   = r;
                        green_on = g;
                        blue_on  = bl;
                    end
                end
                return;
            end
            sh             = 60 - 4 * int'(nib_idx);
            res.brightness = {4'(bright_pat >> sh), rsps_pkg::LOW_NIBBLE};
            res.red        = red_on[bit_idx] ? rsps_pkg::COLOR_ON : rsps_pkg::COLOR_OFF;
            res.green      = green_on[bit_idx] ? rsps_pkg::COLOR_ON : rsps_pkg::COLOR_OFF;
            res.blue       = blue_on[bit_idx] ? rsps_pkg::COLOR_ON : rsps_pkg::COLOR_OFF;
            expected_q.push_back(res);
            bit_idx = bit_idx + 3'd1;
            nib_idx = nib_idx + 4'd1;
            if (swap_pending)
            begin
                swap_count = swap_count - 4'd1;
                if (swap_count == 4'd0)
                begin
                    swap_pending = 1'b0;
                    swap_count   = 4'(SWAP_TICKS);
                    red_on       = red_next;
                    green_on     = green_next;
                    blue_on      = blue_next;
                end
            end
        endfunction

        function void check_result(logic [7:0] b, logic [7:0] r, logic [7:0] g, logic [7:0] bl);
            rsps_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no request waiting: brightness %0d red %0d green %0d blue %0d",
                       b, r, g, bl);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (b !== want.brightness)
            begin
                $error("brightness mismatch: expected %0d, actual %0d", want.brightness, b);
                errors++;
            end
            if (r !== want.red)
            begin
                $error("red mismatch: expected %0d, actual %0d", want.red, r);
                errors++;
            end
            if (g !== want.green)
            begin
                $error("green mismatch: expected %0d, actual %0d", want.green, g);
                errors++;
            end
            if (bl !== want.blue)
            begin
                $error("blue mismatch: expected %0d, actual %0d", want.blue, bl);
                errors++;
            end
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       cmd          = rsps_pkg::CMD_TICK;
    logic [2:0] status_code  = rsps_pkg::ST_INIT;
    logic       defer_colors = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] brightness;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    status_scoreboard sb;
    int               n_accepted  = 0;
    int               cycle_count = 0;
    logic             long_hold   = 1'b0;
    logic             no_idle     = 1'b0;

    rgb_status_pattern_sequencer #(
        .SWAP_DELAY_TICKS(SWAP_TICKS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .status_code (status_code),
        .defer_colors(defer_colors),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .brightness  (brightness),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic c, input logic [2:0] code, input logic defer);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        status_code  <= code;
        defer_colors <= defer;
        do @(posedge clk); while (in_stall);
        sb.note_request(c, code, defer);
        n_accepted++;
    endtask

    task automatic tick(input int n);
        repeat (n)
            send_request(rsps_pkg::CMD_TICK, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : receiver
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(brightness, red, green, blue);
            if (hold > 0)
                hold--;
            else
                hold = pick_gap();
            out_stall <= long_hold || (hold > 0);
        end
    end

    initial
    begin : long_stall
        wait (n_accepted >= 300);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin : stimulus
        int         r;
        logic       c;
        logic [2:0] code;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tick(1);
        send_request(rsps_pkg::CMD_SET, 3'd7, 1'b0);
        tick(1);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_INIT, 1'b0);
        tick(2);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_VOLUME, 1'b0);
        tick(1);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_LED_CHANGED, 1'b0);
        tick(1);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_CHANNEL_CHANGED, 1'b0);
        tick(1);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_IDLE, 1'b0);
        tick(1);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_VOLUME, 1'b1);
        tick(3);
        send_request(rsps_pkg::CMD_SET, rsps_pkg::ST_INIT, 1'b1);
        tick(5);
        send_request(rsps_pkg::CMD_SET, 3'd5, 1'b1);
        send_request(rsps_pkg::CMD_SET, 3'd6, 1'b0);
        tick(2);
        wait_for_results();

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            no_idle <= (i >= 650 && i < 750);
            if (i == 500)
                wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                c    = rsps_pkg::CMD_TICK;
                code = 3'($urandom_range(0, 7));
            end
            else
            begin
                c    = rsps_pkg::CMD_SET;
                code = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            end
            send_request(c, code, 1'($urandom_range(0, 1)));
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
